// ===== rtl/core/hbs_pkg.sv =====
// Package for the HDLC bit-stuffing serializer.
// Holds request codes, configuration indexes, constants and the result type.
// No dependencies.
package hbs_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 128;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam logic [2:0] STUFF_LIMIT  = 3'd5;
  localparam logic [7:0] OPEN_RESET   = 8'd100;
  localparam logic [7:0] CLOSE_RESET  = 8'd50;
  localparam logic [7:0] SEL_FIRST    = 8'h01;

  // Request codes carried in the req_type field.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2
  } req_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_FLAGS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_FLAGS = 1'd1;

  // One result transaction.
  typedef struct packed {
    logic bit_valid;
    logic bit_value;
    logic bit_is_stuffed;
    logic transmit_active;
  } result_t;

endpackage

// ===== rtl/core/hbs_frame_buf.sv =====
// Frame byte store: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
// Depends on nothing but its parameters.
module hbs_frame_buf #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q_r;
  logic       fwd_r;
  logic [7:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r    <= mem[rd_addr];
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  // The memory returns the old byte when read and written together.
  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

// ===== rtl/core/hbs_out_queue.sv =====
// Two-entry result queue that decouples the bit engine from the output side.
// Depends on hbs_pkg.
module hbs_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hbs_pkg::result_t push_data,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output hbs_pkg::result_t out_data
);

  hbs_pkg::result_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign can_push  = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/hdlc_bit_stuffing_serializer.sv =====
// Top level of the HDLC bit-stuffing serializer (pre-NRZI bit stream).
// Depends on hbs_pkg, hbs_frame_buf and hbs_out_queue.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_ready  req_type, byte_address, byte_value, frame_length
//   out_      output     out_valid/out_ready bit_valid, bit_value, bit_is_stuffed,
//                                           transmit_active
//   cfg_      input      cfg_we (no wait)   cfg_index, cfg_wdata
//
// Every input transaction yields exactly one output transaction. One input
// transaction is taken per clock cycle while in_ready is high; the limit is the single
// decision step that updates the bit counters, plus the registered frame buffer read.
// The buffer is read every cycle at the byte position that will hold after
// the current cycle, so the byte under transmission is always ready.
// Reset is synchronous and active low; no clearing pass is needed.
// in_ready drops only while both entries of the output queue are full.
module hdlc_bit_stuffing_serializer #(
  parameter int unsigned BUFFER_DEPTH = hbs_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input transactions.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_req_type,
  input  logic [6:0]                    in_byte_address,
  input  logic [7:0]                    in_byte_value,
  input  logic [7:0]                    in_frame_length,
  // Output transactions.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit_valid,
  output logic                          out_bit_value,
  output logic                          out_bit_is_stuffed,
  output logic                          out_transmit_active,
  // Configuration writes.
  input  logic                          cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  // Configuration registers.
  logic [7:0] open_count_r;
  logic [7:0] close_count_r;

  // Transmit state.
  logic [AW-1:0] pos_r,        pos_nxt;
  logic [7:0]    sel_r,        sel_nxt;
  logic [7:0]    bytes_left_r, bytes_left_nxt;
  logic [7:0]    open_left_r,  open_left_nxt;
  logic [7:0]    close_left_r, close_left_nxt;
  logic [2:0]    ones_r,       ones_nxt;

  logic             accept;
  logic             buf_wr_en;
  logic [AW-1:0]    buf_wr_addr;
  logic [7:0]       cur_byte;
  logic             can_push;
  logic             sel_wrap;
  logic [7:0]       sel_shift;
  logic             flag_b;
  logic             data_b;
  hbs_pkg::result_t res;
  hbs_pkg::result_t out_res;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  // Writes beyond the buffer are dropped; the address field may be wider
  // or narrower than the buffer index.
  assign buf_wr_en   = accept && (in_req_type == hbs_pkg::REQ_WRITE)
                       && (32'(in_byte_address) < BUFFER_DEPTH);
  assign buf_wr_addr = AW'(in_byte_address);

  hbs_frame_buf #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_frame_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (in_byte_value),
    .rd_addr (pos_nxt),
    .rd_data (cur_byte)
  );

  // Bit selection walks one position per flag or data bit, holds on a stuffed zero, and wraps after bit 7.
  assign sel_shift = {sel_r[6:0], 1'b0};
  assign sel_wrap  = (sel_shift == 8'h00);
  assign flag_b    = |(hbs_pkg::FLAG_PATTERN & sel_r);
  assign data_b    = |(cur_byte & sel_r);

  always_comb begin
    pos_nxt        = pos_r;
    sel_nxt        = sel_r;
    bytes_left_nxt = bytes_left_r;
    open_left_nxt  = open_left_r;
    close_left_nxt = close_left_r;
    ones_nxt       = ones_r;
    res            = '0;

    if (accept) begin
      case (in_req_type)
        hbs_pkg::REQ_START: begin
          // A start abandons any frame in flight but keeps the run of ones.
          pos_nxt        = '0;
          sel_nxt        = hbs_pkg::SEL_FIRST;
          open_left_nxt  = open_count_r;
          close_left_nxt = close_count_r;
          bytes_left_nxt = in_frame_length;
        end
        hbs_pkg::REQ_TICK: begin
          if (ones_r == hbs_pkg::STUFF_LIMIT) begin
            // A pending stuffed zero goes out before anything else.
            res.bit_valid      = 1'b1;
            res.bit_is_stuffed = 1'b1;
            ones_nxt           = '0;
          end else if (bytes_left_r != 8'd0) begin
            res.bit_valid = 1'b1;
            sel_nxt       = sel_wrap ? hbs_pkg::SEL_FIRST : sel_shift;
            if (open_left_r != 8'd0) begin
              // Flag ones do not count toward stuffing; flag zeros end a run.
              res.bit_value = flag_b;
              if (!flag_b) begin
                ones_nxt = '0;
              end
              if (sel_wrap) begin
                open_left_nxt = open_left_r - 8'd1;
              end
            end else begin
              res.bit_value = data_b;
              ones_nxt      = data_b ? 3'(ones_r + 3'd1) : 3'd0;
              if (sel_wrap) begin
                pos_nxt        = (pos_r == AW'(BUFFER_DEPTH - 1)) ? '0 : pos_r + AW'(1);
                bytes_left_nxt = bytes_left_r - 8'd1;
              end
            end
          end else if (close_left_r != 8'd0) begin
            res.bit_valid = 1'b1;
            res.bit_value = flag_b;
            sel_nxt       = sel_wrap ? hbs_pkg::SEL_FIRST : sel_shift;
            if (!flag_b) begin
              ones_nxt = '0;
            end
            if (sel_wrap) begin
              close_left_nxt = close_left_r - 8'd1;
            end
          end
        end
        default: begin
          // Writes go to the buffer; unknown codes change nothing.
        end
      endcase
    end

    res.transmit_active = (bytes_left_nxt != 8'd0) || (close_left_nxt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      sel_r         <= hbs_pkg::SEL_FIRST;
      bytes_left_r  <= '0;
      open_left_r   <= '0;
      close_left_r  <= '0;
      ones_r        <= '0;
      open_count_r  <= hbs_pkg::OPEN_RESET;
      close_count_r <= hbs_pkg::CLOSE_RESET;
    end else begin
      pos_r        <= pos_nxt;
      sel_r        <= sel_nxt;
      bytes_left_r <= bytes_left_nxt;
      open_left_r  <= open_left_nxt;
      close_left_r <= close_left_nxt;
      ones_r       <= ones_nxt;
      if (cfg_we) begin
        case (cfg_index)
          hbs_pkg::CFG_OPEN_FLAGS:  open_count_r  <= cfg_wdata;
          hbs_pkg::CFG_CLOSE_FLAGS: close_count_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Results queue up here so a stalled consumer does not stop the engine
  // until both entries are taken.
  hbs_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_bit_valid       = out_res.bit_valid;
  assign out_bit_value       = out_res.bit_value;
  assign out_bit_is_stuffed  = out_res.bit_is_stuffed;
  assign out_transmit_active = out_res.transmit_active;

endmodule
